@@ design/assert_macros.svh @@
// assertion macros used by the design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_SYNC_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop)
`define ASSERT_SYNC_MSG(label, clk, rst, prop, msg)
`endif
`endif

@@ design/hmt_pkg.sv @@
// types and codes of the heartbeat membership table
`timescale 1ns / 1ps
package hmt_pkg;
   localparam logic [2:0] CMD_JOIN_REQ = 3'd0;
   localparam logic [2:0] CMD_JOIN_REP = 3'd1;
   localparam logic [2:0] CMD_PING     = 3'd2;
   localparam logic [2:0] CMD_GOSSIP   = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;

   localparam logic [3:0] KIND_ADDED        = 4'd0;
   localparam logic [3:0] KIND_PRESENT      = 4'd1;
   localparam logic [3:0] KIND_REFRESHED    = 4'd2;
   localparam logic [3:0] KIND_IGNORED      = 4'd3;
   localparam logic [3:0] KIND_FULL         = 4'd4;
   localparam logic [3:0] KIND_REMOVED      = 4'd5;
   localparam logic [3:0] KIND_PING         = 4'd6;
   localparam logic [3:0] KIND_NOT_IN_GROUP = 4'd7;
   localparam logic [3:0] KIND_TICK_EMPTY   = 4'd8;

   localparam logic [1:0] CSR_SELF_ID   = 2'd0;
   localparam logic [1:0] CSR_SELF_PORT = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] beat;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_MISS, S_REM, S_PING, S_FIN
   } state_type;
endpackage

@@ design/heartbeat_membership_table.sv @@
// heartbeat membership table: top level with entry memory and scan sequencer
//
// channel  dir  handshake            beat contents
// req      in   req_valid/req_stall  cmd, peer id/port/heartbeat/stamp, now
// rsp      out  rsp_valid/rsp_stall  kind, id, port, send_reply, last
// csr      in   csr_valid/csr_ready  register index, write data
//
// one item at a time; a lookup scans the table one entry per cycle, and
// a tick in the group scans it twice, removal pass then ping pass; both
// passes and the final result wait while the result side stalls
// entries sit in one memory with a registered read port
// synchronous reset clears count, group flag, own beat, self id and port and sets the timeout to 20;
// table contents need no clearing, only slots below the count are read
`timescale 1ns / 1ps
`include "assert_macros.svh"
module heartbeat_membership_table #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_peer_id,
   input  logic [15:0] req_peer_port,
   input  logic [31:0] req_peer_heartbeat,
   input  logic [31:0] req_peer_stamp,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [31:0] rsp_out_id,
   output logic [15:0] rsp_out_port,
   output logic        rsp_send_reply,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import hmt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE = CW'(1);

   // entry memory
   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // configuration
   logic [31:0] self_id_ff;
   logic [15:0] self_port_ff;
   logic [15:0] timeout_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff   <= '0;
         self_port_ff <= '0;
         timeout_ff   <= 16'd20;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SELF_ID:   self_id_ff   <= csr_wdata;
            CSR_SELF_PORT: self_port_ff <= csr_wdata[15:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // control and latched item
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, wptr_ff, wptr_in, surv_ff, surv_in;
   logic          group_ff, group_in;
   logic [31:0]   own_beat_ff, own_beat_in;
   logic [2:0]    cmd_ff;
   logic [31:0]   id_ff, hb_ff, stamp_ff, now_ff;
   logic [15:0]   port_ff;
   logic [3:0]    res_kind_ff, res_kind_in;
   logic          res_zero_ff, res_zero_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  kind_ff, kind_in;
   logic [31:0] oid_ff, oid_in;
   logic [15:0] oport_ff, oport_in;
   logic        reply_ff, reply_in, last_ff, last_in;

   function automatic logic aged(input logic [31:0] t_now, input logic [31:0] t_stamp,
                                 input logic [15:0] t_out);
      logic [31:0] d;
      d = t_now - t_stamp;
      return !d[31] && (d >= {16'd0, t_out});
   endfunction

   logic accept, out_free, hit, rd_aged, at_top, in_group_now, is_self, last_surv;

   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign hit          = (rd_ff.id == id_ff) && (rd_ff.port == port_ff);
   assign rd_aged      = aged(now_ff, rd_ff.stamp, timeout_ff);
   assign at_top       = (idx_ff == count_ff - ONE);
   assign in_group_now = group_ff || (self_id_ff == 32'd1 && self_port_ff == 16'd0);
   assign is_self      = (id_ff == self_id_ff) && (port_ff == self_port_ff);
   assign last_surv    = (wptr_ff + ONE == surv_ff);
   assign req_stall    = (state_ff != S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd inside {CMD_JOIN_REQ, CMD_JOIN_REP, CMD_PING, CMD_GOSSIP})
                  state_in = (count_ff == '0) ? S_MISS : S_LOOK;
               else if (req_cmd == CMD_TICK && in_group_now && count_ff != '0)
                  state_in = S_REM;
               else
                  state_in = S_FIN;
            end
         end
         S_LOOK: begin
            if (hit) state_in = S_FIN;
            else if (at_top) state_in = S_MISS;
         end
         S_MISS: state_in = S_FIN;
         S_REM: begin
            if ((!rd_aged || out_free) && idx_ff == '0)
               state_in = (surv_ff == '0 && rd_aged) ? S_IDLE : S_PING;
         end
         S_PING: begin
            if ((rd_aged || out_free) && at_top) state_in = S_IDLE;
         end
         S_FIN: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      wptr_in     = wptr_ff;
      surv_in     = surv_ff;
      group_in    = group_ff;
      own_beat_in = own_beat_ff;
      res_kind_in = res_kind_ff;
      res_zero_in = res_zero_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = rd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in     = kind_ff;
      oid_in      = oid_ff;
      oport_in    = oport_ff;
      reply_in    = reply_ff;
      last_in     = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_zero_in = 1'b0;
               res_kind_in = KIND_IGNORED;
               idx_in      = '0;
               wptr_in     = '0;
               surv_in     = '0;
               if (req_cmd == CMD_JOIN_REP) group_in = 1'b1;
               if (req_cmd inside {CMD_JOIN_REQ, CMD_JOIN_REP, CMD_PING, CMD_GOSSIP}) begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else if (req_cmd == CMD_TICK) begin
                  res_zero_in = 1'b1;
                  if (!in_group_now) begin
                     res_kind_in = KIND_NOT_IN_GROUP;
                  end else begin
                     res_kind_in = KIND_TICK_EMPTY;
                     if (own_beat_ff != '1) own_beat_in = own_beat_ff + 32'd1;
                     idx_in  = count_ff - ONE;
                     rd_en   = 1'b1;
                     rd_addr = idx_in[AW-1:0];
                  end
               end
            end
         end
         S_LOOK: begin
            if (hit) begin
               case (cmd_ff)
                  CMD_PING: begin
                     wr_en       = 1'b1;
                     wr_data.beat  = (rd_ff.beat == '1) ? rd_ff.beat : rd_ff.beat + 32'd1;
                     wr_data.stamp = now_ff;
                     res_kind_in = KIND_REFRESHED;
                  end
                  CMD_GOSSIP: begin
                     if (hb_ff > rd_ff.beat) begin
                        wr_en         = 1'b1;
                        wr_data.beat  = hb_ff;
                        wr_data.stamp = now_ff;
                        res_kind_in   = KIND_REFRESHED;
                     end else begin
                        res_kind_in = KIND_IGNORED;
                     end
                  end
                  default: res_kind_in = KIND_PRESENT;
               endcase
            end else if (!at_top) begin
               idx_in  = idx_ff + ONE;
               rd_en   = 1'b1;
               rd_addr = idx_in[AW-1:0];
            end
         end
         S_MISS: begin
            if (cmd_ff == CMD_GOSSIP && (is_self || aged(now_ff, stamp_ff, timeout_ff))) begin
               res_kind_in = KIND_IGNORED;
            end else if (count_ff == FULL_COUNT) begin
               res_kind_in = KIND_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[AW-1:0];
               wr_data.id    = id_ff;
               wr_data.port  = port_ff;
               wr_data.beat  = (cmd_ff == CMD_GOSSIP) ? hb_ff : 32'd1;
               wr_data.stamp = (cmd_ff == CMD_GOSSIP) ? stamp_ff : now_ff;
               count_in      = count_ff + ONE;
               res_kind_in   = KIND_ADDED;
            end
         end
         // removal pass, top slot down
         S_REM: begin
            if (!rd_aged || out_free) begin
               if (rd_aged) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_REMOVED;
                  oid_in       = rd_ff.id;
                  oport_in     = rd_ff.port;
                  reply_in     = 1'b0;
                  last_in      = (idx_ff == '0) && (surv_ff == '0);
               end else begin
                  surv_in = surv_ff + ONE;
               end
               if (idx_ff == '0) begin
                  if (surv_ff == '0 && rd_aged) count_in = '0;
                  idx_in  = '0;
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else begin
                  idx_in  = idx_ff - ONE;
                  rd_en   = 1'b1;
                  rd_addr = idx_in[AW-1:0];
               end
            end
         end
         // compaction and ping listing, bottom slot up
         S_PING: begin
            if (rd_aged || out_free) begin
               if (!rd_aged) begin
                  wr_en        = 1'b1;
                  wr_addr      = wptr_ff[AW-1:0];
                  wptr_in      = wptr_ff + ONE;
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_PING;
                  oid_in       = rd_ff.id;
                  oport_in     = rd_ff.port;
                  reply_in     = 1'b0;
                  last_in      = last_surv;
               end
               if (at_top) begin
                  count_in = surv_ff;
               end else begin
                  idx_in  = idx_ff + ONE;
                  rd_en   = 1'b1;
                  rd_addr = idx_in[AW-1:0];
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = res_kind_ff;
               oid_in       = res_zero_ff ? 32'd0 : id_ff;
               oport_in     = res_zero_ff ? 16'd0 : port_ff;
               reply_in     = (cmd_ff == CMD_JOIN_REQ);
               last_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         group_ff     <= 1'b0;
         own_beat_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         group_ff     <= group_in;
         own_beat_ff  <= own_beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         id_ff    <= req_peer_id;
         port_ff  <= req_peer_port;
         hb_ff    <= req_peer_heartbeat;
         stamp_ff <= req_peer_stamp;
         now_ff   <= req_now;
      end
      idx_ff      <= idx_in;
      wptr_ff     <= wptr_in;
      surv_ff     <= surv_in;
      res_kind_ff <= res_kind_in;
      res_zero_ff <= res_zero_in;
      kind_ff     <= kind_in;
      oid_ff      <= oid_in;
      oport_ff    <= oport_in;
      reply_ff    <= reply_in;
      last_ff     <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_id     = oid_ff;
   assign rsp_out_port   = oport_ff;
   assign rsp_send_reply = reply_ff;
   assign rsp_last       = last_ff;

   // checks
   `ASSERT_SYNC_MSG(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "count above depth")
   `ASSERT_SYNC(a_compact_order, clock, reset, (state_ff == S_PING && wr_en) |-> wptr_ff <= idx_ff)
   `ASSERT_SYNC(a_idle_no_write, clock, reset, (state_ff == S_IDLE) |-> !wr_en)
endmodule

@@ tb/heartbeat_membership_table_tb.sv @@
// testbench for the heartbeat membership table: directed and random commands against a predictor
`timescale 1ns / 1ps
module heartbeat_membership_table_tb;
   import hmt_pkg::*;

   localparam int DEPTH = 32;
   localparam longint CYCLE_LIMIT = 3000000;

   // result beat as the checker sees it
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] id;
      logic [15:0] port;
      logic        reply;
      logic        last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [31:0] req_peer_id = '0;
   logic [15:0] req_peer_port = '0;
   logic [31:0] req_peer_heartbeat = '0;
   logic [31:0] req_peer_stamp = '0;
   logic [31:0] req_now = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [31:0] rsp_out_id;
   logic [15:0] rsp_out_port;
   logic        rsp_send_reply;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   heartbeat_membership_table #(.TABLE_DEPTH(DEPTH)) uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state: own copy of the table and registers
   logic [31:0] cfg_self_id;
   logic [15:0] cfg_self_port;
   logic [15:0] cfg_timeout;
   entry_type   members [DEPTH];
   int          member_total;
   bit          joined;
   logic [31:0] own_beat;

   result_type  pending_results [$];
   int          error_count = 0;
   longint      cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [31:0] clock_now = 32'd1000;

   // signed age compare; a stamp in the future never ages out
   function automatic bit is_stale(logic [31:0] t_now, logic [31:0] stamp);
      logic [31:0] age;
      age = t_now - stamp;
      if (age[31]) return 1'b0;
      return age >= {16'd0, cfg_timeout};
   endfunction

   function automatic int lookup_member(logic [31:0] id, logic [15:0] port);
      for (int i = 0; i < member_total; i++)
         if (members[i].id == id && members[i].port == port) return i;
      return -1;
   endfunction

   function automatic logic [3:0] store_member(logic [31:0] id, logic [15:0] port,
                                               logic [31:0] beat, logic [31:0] stamp);
      if (member_total >= DEPTH) return KIND_FULL;
      members[member_total] = '{id: id, port: port, beat: beat, stamp: stamp};
      member_total++;
      return KIND_ADDED;
   endfunction

   function automatic void push_result(logic [3:0] kind, logic [31:0] id,
                                       logic [15:0] port, logic reply);
      result_type item;
      item = '{kind: kind, id: id, port: port, reply: reply, last: 1'b0};
      pending_results.insert(pending_results.size(), item);
   endfunction

   // work out the results of one accepted command
   function automatic void predict_command(logic [2:0] cmd, logic [31:0] id,
                                           logic [15:0] port, logic [31:0] hb,
                                           logic [31:0] stamp, logic [31:0] t_now);
      int slot;
      int first;
      logic [3:0] kind;
      first = pending_results.size();
      case (cmd)
         CMD_JOIN_REQ: begin
            kind = (lookup_member(id, port) >= 0) ? KIND_PRESENT
                 : store_member(id, port, 32'd1, t_now);
            push_result(kind, id, port, 1'b1);
         end
         CMD_JOIN_REP: begin
            kind = (lookup_member(id, port) >= 0) ? KIND_PRESENT
                 : store_member(id, port, 32'd1, t_now);
            joined = 1'b1;
            push_result(kind, id, port, 1'b0);
         end
         CMD_PING: begin
            slot = lookup_member(id, port);
            if (slot >= 0) begin
               if (members[slot].beat != '1) members[slot].beat++;
               members[slot].stamp = t_now;
               kind = KIND_REFRESHED;
            end else kind = store_member(id, port, 32'd1, t_now);
            push_result(kind, id, port, 1'b0);
         end
         CMD_GOSSIP: begin
            slot = lookup_member(id, port);
            if (slot >= 0) begin
               if (hb > members[slot].beat) begin
                  members[slot].beat = hb;
                  members[slot].stamp = t_now;
                  kind = KIND_REFRESHED;
               end else kind = KIND_IGNORED;
            end else if ((id == cfg_self_id && port == cfg_self_port) || is_stale(t_now, stamp))
               kind = KIND_IGNORED;
            else kind = store_member(id, port, hb, stamp);
            push_result(kind, id, port, 1'b0);
         end
         CMD_TICK: begin
            if (!(joined || (cfg_self_id == 32'd1 && cfg_self_port == 16'd0)))
               push_result(KIND_NOT_IN_GROUP, '0, '0, 1'b0);
            else begin
               if (own_beat != '1) own_beat++;
               // remove from the top slot down, closing the gap
               for (int i = member_total - 1; i >= 0; i--)
                  if (is_stale(t_now, members[i].stamp)) begin
                     push_result(KIND_REMOVED, members[i].id, members[i].port, 1'b0);
                     for (int j = i; j + 1 < member_total; j++) members[j] = members[j + 1];
                     member_total--;
                  end
               for (int i = 0; i < member_total; i++)
                  push_result(KIND_PING, members[i].id, members[i].port, 1'b0);
               if (pending_results.size() == first)
                  push_result(KIND_TICK_EMPTY, '0, '0, 1'b0);
            end
         end
         default: push_result(KIND_IGNORED, id, port, 1'b0);
      endcase
      pending_results[pending_results.size() - 1].last = 1'b1;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result checker plus random receiver stall
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{kind: rsp_kind, id: rsp_out_id, port: rsp_out_port,
                  reply: rsp_send_reply, last: rsp_last};
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result beat %p", seen);
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               error_count++;
               if (error_count <= 10) $display("mismatch: expected %p got %p", want, seen);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // send one command beat, predicting at acceptance; valid drops only while idling
   task automatic send_command(logic [2:0] cmd, logic [31:0] id, logic [15:0] port,
                               logic [31:0] hb, logic [31:0] stamp, logic [31:0] t_now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_peer_id <= id;
      req_peer_port <= port;
      req_peer_heartbeat <= hb;
      req_peer_stamp <= stamp;
      req_now <= t_now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(cmd, id, port, hb, stamp, t_now);
   endtask

   // valid stays high for the caller to drop after the last write
   task automatic write_register(logic [1:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_SELF_ID:   cfg_self_id = value;
         CSR_SELF_PORT: cfg_self_port = value[15:0];
         CSR_TIMEOUT:   cfg_timeout = value[15:0];
         default: ;
      endcase
   endtask

   // wait for the block to drain before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);
   endtask

   task automatic tick(logic [31:0] t_now);
      send_command(CMD_TICK, '0, '0, '0, '0, t_now);
   endtask

   // out of group, join flow, every command and the field extremes
   task automatic test_directed();
      tick(clock_now);
      send_command(CMD_JOIN_REQ, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, clock_now);
      send_command(CMD_JOIN_REQ, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, clock_now);
      send_command(CMD_JOIN_REP, 32'd0, 16'd0, '0, '0, clock_now);
      send_command(CMD_PING, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, clock_now + 1);
      send_command(CMD_PING, 32'd7, 16'd7, '0, '0, clock_now);
      // gossip: saturated beat, self, aged, future stamp, lower beat
      send_command(CMD_GOSSIP, 32'd7, 16'd7, 32'hFFFF_FFFF, '0, clock_now);
      send_command(CMD_PING, 32'd7, 16'd7, '0, '0, clock_now + 2);
      send_command(CMD_GOSSIP, 32'd7, 16'd7, 32'd3, '0, clock_now);
      send_command(CMD_GOSSIP, cfg_self_id, cfg_self_port, 32'd9, clock_now, clock_now);
      send_command(CMD_GOSSIP, 32'd8, 16'd8, 32'd9, clock_now - 20, clock_now);
      send_command(CMD_GOSSIP, 32'd9, 16'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_command(CMD_GOSSIP, 32'd10, 16'd10, 32'd4, clock_now - 19, clock_now);
      // unknown commands echo id and port
      send_command(3'd5, 32'hA5A5_5A5A, 16'h5A5A, '1, '1, '1);
      send_command(3'd6, 32'd1, 16'd2, '0, '0, '0);
      send_command(3'd7, 32'd3, 16'd4, '0, '0, '0);
      tick(clock_now + 5);
      tick(clock_now + 100);
      tick(clock_now + 200);
      // fill the table past its depth
      for (int i = 0; i < DEPTH + 2; i++)
         send_command(CMD_PING, 32'h100 + i, 16'(i), '0, '0, clock_now + 300);
      tick(clock_now + 301);
      tick(clock_now + 400);
      wait_drained();
   endtask

   // random traffic over a small id space so hits are common
   task automatic test_random(int count);
      logic [2:0]  cmd;
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] hb;
      logic [31:0] stamp;
      for (int n = 0; n < count; n++) begin
         clock_now += $urandom_range(3);
         if ($urandom_range(9) == 0) begin
            id = $urandom;
            port = 16'($urandom);
            cmd = 3'($urandom_range(7));
         end else begin
            id = 32'h40 + $urandom_range(40);
            port = 16'($urandom_range(2));
            cmd = ($urandom_range(5) == 0) ? CMD_TICK : 3'($urandom_range(3));
         end
         hb = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8);
         stamp = ($urandom_range(3) == 0) ? $urandom : clock_now - $urandom_range(40);
         if ($urandom_range(30) == 0) begin
            id = cfg_self_id;
            port = cfg_self_port;
         end
         send_command(cmd, id, port, hb, stamp, clock_now);
      end
      wait_drained();
   endtask

   task automatic test_settings(logic [31:0] id, logic [15:0] port, logic [15:0] timeout,
                                int count);
      write_register(CSR_SELF_ID, id);
      write_register(CSR_SELF_PORT, {16'd0, port});
      write_register(CSR_TIMEOUT, {16'd0, timeout});
      csr_valid <= 1'b0;
      test_random(count);
   endtask

   initial begin
      cfg_self_id = '0;
      cfg_self_port = '0;
      cfg_timeout = 16'd20;
      member_total = 0;
      joined = 1'b0;
      own_beat = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 33;
      recv_stall_pct = 62;
      test_directed();
      // introducer is in the group from reset, timeout extremes
      test_settings(32'd1, 16'd0, 16'd65535, 60);
      test_settings(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 60);

      send_idle_pct = 62;
      recv_stall_pct = 33;
      test_settings(32'h40, 16'd1, 16'd30, 100);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_settings(32'h41, 16'd0, 16'd12, 130);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
